// ----- rtl/qts_pkg.sv -----
// qts_pkg: shared constants, codes and controller/datapath link types
// for the two-stack queue. No dependencies.

package qts_pkg;

  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_FRONT = 2'd2,
    OP_LIST  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // where the data field of an emitted result comes from
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_TOP,
    SRC_LIST
  } src_e;

  typedef struct packed {
    logic    latch;
    logic    push;
    logic    xfer_rd;
    logic    xfer_wr;
    logic    top_rd;
    logic    pop;
    logic    list_init;
    logic    list_rd;
    logic    list_step;
    logic    emit;
    status_e status;
    src_e    src;
  } qts_cmd_t;

  typedef struct packed {
    op_e  op;
    logic in_full;
    logic in_empty;
    logic out_empty;
    logic slot_free;
    logic list_last;
  } qts_sts_t;

endpackage

// ----- rtl/qts_in_if.sv -----
// qts_in_if / qts_out_if: valid/ready channels for queue requests and results.
// Depends on qts_pkg.

interface qts_in_if import qts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

interface qts_out_if import qts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     last;

  modport source (output valid, status, data, last, input ready);
  modport sink   (input valid, status, data, last, output ready);
endinterface

// ----- rtl/qts_ram.sv -----
// qts_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module qts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/qts_datapath.sv -----
// qts_datapath: stack memories, stack counts, list cursor and result register.
// Depends on qts_pkg and qts_ram.

module qts_datapath import qts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qts_cmd_t                 cmd_i,
  output qts_sts_t                 sts_o,
  input  logic [1:0]               op_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [1:0]               out_status_o,
  output logic signed [DATA_W-1:0] out_data_o,
  output logic                     out_last_o
);

  typedef enum logic {
    SIDE_OUT,
    SIDE_IN
  } side_e;

  op_e                      op_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]         in_cnt_q, in_cnt_d;
  logic [CNT_W-1:0]         out_cnt_q, out_cnt_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  side_e                    side_q, side_d;
  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q;
  logic signed [DATA_W-1:0] out_data_q;
  logic                     out_last_q;

  logic [CNT_W-1:0]  in_top, out_top;
  logic              in_re, out_re;
  logic [PTR_W-1:0]  in_raddr, out_raddr;
  logic [DATA_W-1:0] in_rdata, out_rdata;
  logic              slot_free, list_last;

  assign in_top = in_cnt_q - CNT_W'(1);
  assign out_top = out_cnt_q - CNT_W'(1);

  assign in_re    = cmd_i.xfer_rd | (cmd_i.list_rd & (side_q == SIDE_IN));
  assign in_raddr = cmd_i.xfer_rd ? in_top[PTR_W-1:0] : idx_q[PTR_W-1:0];
  assign out_re    = cmd_i.top_rd | (cmd_i.list_rd & (side_q == SIDE_OUT));
  assign out_raddr = cmd_i.top_rd ? out_top[PTR_W-1:0] : idx_q[PTR_W-1:0];

  qts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_in_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (in_cnt_q[PTR_W-1:0]),
    .wdata_i (value_q),
    .re_i    (in_re),
    .raddr_i (in_raddr),
    .rdata_o (in_rdata)
  );

  // transfer writes what the input stack read returned in the cycle before
  qts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_out_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.xfer_wr),
    .waddr_i (out_cnt_q[PTR_W-1:0]),
    .wdata_i (in_rdata),
    .re_i    (out_re),
    .raddr_i (out_raddr),
    .rdata_o (out_rdata)
  );

  assign slot_free = !out_valid_q || out_ready_i;
  // list order: output stack top down, then input stack bottom up
  assign list_last = (side_q == SIDE_IN) ? (idx_q == in_top)
                                         : ((idx_q == '0) && (in_cnt_q == '0));

  always_comb begin
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    idx_d     = idx_q;
    side_d    = side_q;
    if (cmd_i.push) begin
      in_cnt_d = in_cnt_q + CNT_W'(1);
    end else if (cmd_i.xfer_rd) begin
      in_cnt_d = in_top;
    end
    if (cmd_i.xfer_wr) begin
      out_cnt_d = out_cnt_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      out_cnt_d = out_top;
    end
    if (cmd_i.list_init) begin
      if (out_cnt_q != '0) begin
        side_d = SIDE_OUT;
        idx_d  = out_top;
      end else begin
        side_d = SIDE_IN;
        idx_d  = '0;
      end
    end else if (cmd_i.list_step) begin
      if (side_q == SIDE_IN) begin
        idx_d = idx_q + CNT_W'(1);
      end else if (idx_q == '0) begin
        side_d = SIDE_IN;
      end else begin
        idx_d = idx_q - CNT_W'(1);
      end
    end
    out_valid_d = cmd_i.emit ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      idx_q       <= '0;
      side_q      <= SIDE_OUT;
      out_valid_q <= 1'b0;
    end else begin
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      idx_q       <= idx_d;
      side_q      <= side_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_e'(op_i);
      value_q <= value_i;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.status;
      case (cmd_i.src)
        SRC_TOP:  out_data_q <= out_rdata;
        SRC_LIST: out_data_q <= (side_q == SIDE_IN) ? in_rdata : out_rdata;
        default:  out_data_q <= '0;
      endcase
      out_last_q <= (cmd_i.src == SRC_LIST) ? list_last : 1'b1;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.in_full   = (in_cnt_q == CNT_W'(STACK_DEPTH));
  assign sts_o.in_empty  = (in_cnt_q == '0);
  assign sts_o.out_empty = (out_cnt_q == '0);
  assign sts_o.slot_free = slot_free;
  assign sts_o.list_last = list_last;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- rtl/qts_ctrl.sv -----
// qts_ctrl: sequencing state machine for the two-stack queue.
// Depends on qts_pkg; drives qts_datapath through qts_cmd_t.

module qts_ctrl import qts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  qts_sts_t sts_i,
  output qts_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_XFER_RD,
    S_XFER_WR,
    S_TOP_RD,
    S_TOP_EMIT,
    S_LIST_RD,
    S_LIST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.op == OP_ENQ) begin
          if (sts_i.slot_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.src    = SRC_ZERO;
            cmd_o.status = sts_i.in_full ? ST_OVERFLOW : ST_OK;
            cmd_o.push   = !sts_i.in_full;
            state_d      = S_IDLE;
          end
        end else if (sts_i.in_empty && sts_i.out_empty) begin
          if (sts_i.slot_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.src    = SRC_ZERO;
            cmd_o.status = ST_EMPTY;
            state_d      = S_IDLE;
          end
        end else if (sts_i.op == OP_LIST) begin
          cmd_o.list_init = 1'b1;
          state_d         = S_LIST_RD;
        end else if (sts_i.out_empty) begin
          state_d = S_XFER_RD;
        end else begin
          state_d = S_TOP_RD;
        end
      end
      S_XFER_RD: begin
        cmd_o.xfer_rd = 1'b1;
        state_d       = S_XFER_WR;
      end
      S_XFER_WR: begin
        cmd_o.xfer_wr = 1'b1;
        state_d       = sts_i.in_empty ? S_TOP_RD : S_XFER_RD;
      end
      S_TOP_RD: begin
        cmd_o.top_rd = 1'b1;
        state_d      = S_TOP_EMIT;
      end
      S_TOP_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.src    = SRC_TOP;
          cmd_o.status = ST_OK;
          cmd_o.pop    = (sts_i.op == OP_DEQ);
          state_d      = S_IDLE;
        end
      end
      S_LIST_RD: begin
        cmd_o.list_rd = 1'b1;
        state_d       = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.src    = SRC_LIST;
          cmd_o.status = ST_OK;
          if (sts_i.list_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.list_step = 1'b1;
            state_d         = S_LIST_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_ready_o <= (state_d == S_IDLE);
    end
  end

endmodule

// ----- rtl/queue_from_two_stacks.sv -----
// FIFO queue of signed 32-bit values built from an input stack and an output
// stack, each STACK_DEPTH entries (qts_pkg). Requests arrive on in_i and are
// handled one at a time; results leave through a result register on out_o, so
// a new request is taken while an earlier result still waits. Enqueue latches
// the request, then pushes and answers. Dequeue and front read the output
// stack top, then emit it; first, when the output stack is empty, the input
// stack is poured over, each entry moved by one read, then one write (the
// controller does not overlap the two). List emits one result per held value,
// one stack-memory read per result; an empty-queue answer needs no read.
// A stalled result register holds each answer back until it frees. Depends on
// qts_pkg, the channel interfaces, qts_ctrl and qts_datapath.

module queue_from_two_stacks import qts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  qts_in_if.sink    in_i,
  qts_out_if.source out_o
);

  qts_cmd_t cmd;
  qts_sts_t sts;

  qts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qts_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (in_i.op),
    .value_i      (in_i.value),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_data_o   (out_o.data),
    .out_last_o   (out_o.last)
  );

endmodule
